// ----- sv/hsv_to_rgb_converter_macros.svh -----
// ----------------------------------------------------------------------------
// hsv to rgb converter assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define HSV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hsv_to_rgb_converter assertion failed");

// next-cycle implication, masked while reset is asserted
`define HSV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_converter assertion failed");

// next-cycle implication that also holds through reset
`define HSV_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_converter assertion failed");

`endif

// ----- sv/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared widths, fixed-point constants and stage types of the hsv to rgb path
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int HUE_W      = 16;
    localparam int CH_W       = 8;
    localparam int FRAC_W     = 10;
    localparam int IDX_W      = 7;
    localparam int QT_W       = 18;
    localparam int YQT_W      = 26;
    localparam int YP_W       = 16;
    localparam int ZQT_W      = 20;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int NUM_STAGES = 6;

    localparam int HUE_SECTOR = 960;
    localparam int SECTORS    = 6;
    localparam int FULL_SCALE = 255;
    localparam int QT_SCALE   = 244800;
    localparam int QT_DIV     = 3825;     // 244800 / 64
    localparam int RECIP_15   = 2185;     // ceil(2^15 / 15)
    localparam int RECIP_6    = 43;       // ceil(2^8 / 6)
    localparam int RECIP_3825 = 274;      // floor(2^20 / 3825)
    localparam int RECIP_255  = 257;      // floor(2^16 / 255)

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_stage_en;

    typedef struct packed {
        t_sector             sector;
        logic [FRAC_W-1:0]   frac;
        logic [CH_W-1:0]     sat;
        logic [CH_W-1:0]     val;
    } t_sec_data;

    typedef struct packed {
        t_sector             sector;
        logic [CH_W-1:0]     val;
        logic [YQT_W-1:0]    yq;
        logic [YQT_W-1:0]    yt;
        logic [YP_W-1:0]     yp;
    } t_prod_data;

endpackage

// ----- sv/hsv_to_rgb_converter.sv -----
// throughput: one pixel per clock while the sink is ready; six register stages, the last is the output register
// each stage holds while full and blocked, so bubbles are squeezed out under backpressure
// reset: synchronous, active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// streaming hsv to rgb color conversion in fixed point, hue in 1/16 degree
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // hue [15:0], saturation [23:16], brightness_value [31:24]
    input  logic [hsv2rgb_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [hsv2rgb_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);
    import hsv2rgb_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_en;

    t_stage_en  w_en_sec;
    t_stage_en  w_en_scl;
    t_stage_en  w_en_div;
    t_sec_data  w_sec;
    t_prod_data w_prod;

    // a stage loads when empty or when the stage after it moves
    always_comb begin
        w_en[LAST] = !r_vld[LAST] || i_m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
        n_vld[0] = w_en[0] ? i_s_axis_tvalid : r_vld[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            n_vld[i] = w_en[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_en_sec = '{en_a: w_en[0], en_b: w_en[1]};
    assign w_en_scl = '{en_a: w_en[2], en_b: w_en[3]};
    assign w_en_div = '{en_a: w_en[4], en_b: w_en[5]};

    hsv2rgb_sector u_sector (
        .i_clk  (i_clk),
        .i_en   (w_en_sec),
        .i_hue  (i_s_axis_tdata[HUE_W-1:0]),
        .i_sat  (i_s_axis_tdata[HUE_W+CH_W-1:HUE_W]),
        .i_val  (i_s_axis_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W]),
        .o_data (w_sec)
    );

    hsv2rgb_scale u_scale (
        .i_clk  (i_clk),
        .i_en   (w_en_scl),
        .i_data (w_sec),
        .o_data (w_prod)
    );

    hsv2rgb_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en_div),
        .i_data (w_prod),
        .o_rgb  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[LAST];

endmodule

// ----- sv/hsv2rgb_sector.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// splits the hue into a 60 degree sector and the fraction inside it
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
    input  logic                                i_clk,
    input  hsv2rgb_pkg::t_stage_en              i_en,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]       i_hue,
    input  logic [hsv2rgb_pkg::CH_W-1:0]        i_sat,
    input  logic [hsv2rgb_pkg::CH_W-1:0]        i_val,
    output hsv2rgb_pkg::t_sec_data              o_data
);
    import hsv2rgb_pkg::*;

    logic [HUE_W-1:0]  r_hue;
    logic [CH_W-1:0]   r_sat;
    logic [CH_W-1:0]   r_val;
    logic [IDX_W-1:0]  r_idx;
    t_sec_data         r_data;
    t_sec_data         n_data;

    logic [21:0]       w_recip;
    logic [HUE_W-1:0]  w_base;
    logic [HUE_W-1:0]  w_frac_full;
    logic [11:0]       w_six;
    logic [IDX_W-1:0]  w_sec_full;

    // global sector index = floor(hue / 960) = floor((hue >> 6) / 15), 0..68
    assign w_recip = 22'(i_hue[HUE_W-1:6]) * 22'(RECIP_15);

    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_hue <= i_hue;
            r_sat <= i_sat;
            r_val <= i_val;
            r_idx <= w_recip[21:15];
        end
    end

    // the fraction is the same before and after the wrap to one turn
    always_comb begin
        w_base        = HUE_W'(r_idx) * HUE_W'(HUE_SECTOR);
        w_frac_full   = r_hue - w_base;
        w_six         = 12'(r_idx) * 12'(RECIP_6);
        w_sec_full    = r_idx - IDX_W'(w_six[11:8]) * IDX_W'(SECTORS);
        n_data.sector = t_sector'(w_sec_full[2:0]);
        n_data.frac   = w_frac_full[FRAC_W-1:0];
        n_data.sat    = r_sat;
        n_data.val    = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- sv/hsv2rgb_scale.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// forms the p, q and t numerators and scales them by the value
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
    input  logic                     i_clk,
    input  hsv2rgb_pkg::t_stage_en   i_en,
    input  hsv2rgb_pkg::t_sec_data   i_data,
    output hsv2rgb_pkg::t_prod_data  o_data
);
    import hsv2rgb_pkg::*;

    logic [FRAC_W-1:0] w_rfrac;
    logic [QT_W-1:0]   w_sf;
    logic [QT_W-1:0]   w_sg;

    logic [QT_W-1:0]   r_nq;
    logic [QT_W-1:0]   r_nt;
    logic [CH_W-1:0]   r_np;
    logic [CH_W-1:0]   r_val;
    t_sector           r_sector;

    t_prod_data        r_data;
    t_prod_data        n_data;

    always_comb begin
        w_rfrac = FRAC_W'(HUE_SECTOR) - i_data.frac;
        w_sf    = QT_W'(i_data.sat) * QT_W'(i_data.frac);
        w_sg    = QT_W'(i_data.sat) * QT_W'(w_rfrac);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_nq     <= QT_W'(QT_SCALE) - w_sf;
            r_nt     <= QT_W'(QT_SCALE) - w_sg;
            r_np     <= CH_W'(FULL_SCALE) - i_data.sat;
            r_val    <= i_data.val;
            r_sector <= i_data.sector;
        end
    end

    always_comb begin
        n_data.sector = r_sector;
        n_data.val    = r_val;
        n_data.yq     = YQT_W'(r_val) * YQT_W'(r_nq);
        n_data.yt     = YQT_W'(r_val) * YQT_W'(r_nt);
        n_data.yp     = YP_W'(r_val) * YP_W'(r_np);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- sv/hsv2rgb_div.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_div
// constant divisions by reciprocal with one correction step, then the
// sector mux into the output register
// ----------------------------------------------------------------------------
module hsv2rgb_div (
    input  logic                                 i_clk,
    input  hsv2rgb_pkg::t_stage_en               i_en,
    input  hsv2rgb_pkg::t_prod_data              i_data,
    output logic [hsv2rgb_pkg::M_TDATA_W-1:0]    o_rgb
);
    import hsv2rgb_pkg::*;

    logic [ZQT_W-1:0]  w_zq;
    logic [ZQT_W-1:0]  w_zt;
    logic [28:0]       w_mq;
    logic [28:0]       w_mt;
    logic [23:0]       w_mp;

    logic [ZQT_W-1:0]  r_zq;
    logic [ZQT_W-1:0]  r_zt;
    logic [YP_W-1:0]   r_yp;
    logic [CH_W-1:0]   r_qq;
    logic [CH_W-1:0]   r_qt;
    logic [CH_W-1:0]   r_qp;
    logic [CH_W-1:0]   r_val;
    t_sector           r_sector;

    logic [ZQT_W-1:0]  w_rem_q;
    logic [ZQT_W-1:0]  w_rem_t;
    logic [YP_W-1:0]   w_rem_p;
    logic [CH_W-1:0]   w_q;
    logic [CH_W-1:0]   w_t;
    logic [CH_W-1:0]   w_p;

    logic [M_TDATA_W-1:0] r_rgb;
    logic [M_TDATA_W-1:0] n_rgb;

    // 244800 = 64 * 3825: drop six bits exactly, then divide by 3825
    always_comb begin
        w_zq = i_data.yq[YQT_W-1:6];
        w_zt = i_data.yt[YQT_W-1:6];
        w_mq = 29'(w_zq) * 29'(RECIP_3825);
        w_mt = 29'(w_zt) * 29'(RECIP_3825);
        w_mp = 24'(i_data.yp) * 24'(RECIP_255);
    end

    // estimates are exact or one low
    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_zq     <= w_zq;
            r_zt     <= w_zt;
            r_yp     <= i_data.yp;
            r_qq     <= w_mq[27:20];
            r_qt     <= w_mt[27:20];
            r_qp     <= w_mp[23:16];
            r_val    <= i_data.val;
            r_sector <= i_data.sector;
        end
    end

    always_comb begin
        w_rem_q = r_zq - ZQT_W'(r_qq) * ZQT_W'(QT_DIV);
        w_rem_t = r_zt - ZQT_W'(r_qt) * ZQT_W'(QT_DIV);
        w_rem_p = r_yp - YP_W'(r_qp) * YP_W'(FULL_SCALE);
        w_q     = (w_rem_q >= ZQT_W'(QT_DIV))    ? r_qq + CH_W'(1) : r_qq;
        w_t     = (w_rem_t >= ZQT_W'(QT_DIV))    ? r_qt + CH_W'(1) : r_qt;
        w_p     = (w_rem_p >= YP_W'(FULL_SCALE)) ? r_qp + CH_W'(1) : r_qp;
        // packed blue, green, red from the top bits down
        case (r_sector)
            SEC_RED_YEL: n_rgb = {w_p,   w_t,   r_val};
            SEC_YEL_GRN: n_rgb = {w_p,   r_val, w_q};
            SEC_GRN_CYN: n_rgb = {w_t,   r_val, w_p};
            SEC_CYN_BLU: n_rgb = {r_val, w_q,   w_p};
            SEC_BLU_MAG: n_rgb = {r_val, w_p,   w_t};
            default:     n_rgb = {w_q,   w_p,   r_val};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

// ----- sv/hsv_to_rgb_converter_checker.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// port-level checks on reset, stall hold, pipeline latency and grey output
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic [hsv2rgb_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [hsv2rgb_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);
    logic w_in_txn;
    logic w_flow;

    assign w_in_txn = i_s_axis_tvalid && o_s_axis_tready && i_rst_n;
    assign w_flow   = i_m_axis_tready && i_rst_n;

    `HSV_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_m_axis_tvalid)

    `HSV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // with the sink always ready, an accepted transaction shows up at the output valid
    `HSV_ASSERT_NXT(a_latency, i_clk, i_rst_n,
        $past(w_in_txn, 5) && $past(w_flow, 4) && $past(w_flow, 3) &&
        $past(w_flow, 2) && $past(w_flow, 1) && w_flow,
        o_m_axis_tvalid)

    // zero saturation gives a grey of the input value
    `HSV_ASSERT_NXT(a_grey, i_clk, i_rst_n,
        $past(w_in_txn, 5) && $past(i_s_axis_tdata[23:16], 5) == 8'd0 &&
        $past(w_flow, 4) && $past(w_flow, 3) && $past(w_flow, 2) &&
        $past(w_flow, 1) && w_flow,
        o_m_axis_tdata[7:0] == $past(i_s_axis_tdata[31:24], 6) &&
        o_m_axis_tdata[15:8] == $past(i_s_axis_tdata[31:24], 6) &&
        o_m_axis_tdata[23:16] == $past(i_s_axis_tdata[31:24], 6))

endmodule

bind hsv_to_rgb_converter hsv_to_rgb_converter_checker u_checker (.*);
